@@ sv/ppl_pkg.sv @@
// Shared types, constants and the pair case table for the predator-prey lattice block.
package ppl_pkg;

  localparam int unsigned SITES      = 1024;
  localparam int unsigned SITE_W     = 10;
  localparam int unsigned BANK_DEPTH = SITES / 2;
  localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);
  localparam int unsigned THR_W      = 17;
  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [THR_W-1:0] THR_ONE     = THR_W'(65536);
  localparam logic [THR_W-1:0] ALPHA_RESET = THR_W'(21627);
  localparam logic [THR_W-1:0] BETA_RESET  = THR_W'(13107);
  localparam logic [THR_W-1:0] GAMMA_RESET = THR_W'(58982);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_GAMMA = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_ALWAYS = 2'd0,
    SEL_ALPHA  = 2'd1,
    SEL_BETA   = 2'd2,
    SEL_GAMMA  = 2'd3
  } sel_e;

  typedef struct packed {
    logic prey;
    logic pred;
  } cell_t;

  typedef struct packed {
    logic [THR_W-1:0] alpha;
    logic [THR_W-1:0] beta;
    logic [THR_W-1:0] gamma;
  } thr_t;

  // option bits are prey_i prey_j pred_i pred_j
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][1:0] sel;
    logic [2:0][3:0] bits;
  } case_t;

  function automatic case_t case_info(input logic [3:0] code);
    case_t info;
    info = '0;
    case (code)
      4'd1: begin
        info.count = 2'd1; info.sel[0] = SEL_ALWAYS; info.bits[0] = 4'h2;
      end
      4'd2: begin
        info.count = 2'd1; info.sel[0] = SEL_ALWAYS; info.bits[0] = 4'h1;
      end
      4'd3: begin
        info.count = 2'd1; info.sel[0] = SEL_BETA; info.bits[0] = 4'h0;
      end
      4'd4: begin
        info.count = 2'd2;
        info.sel[0] = SEL_ALPHA;  info.bits[0] = 4'hC;
        info.sel[1] = SEL_ALWAYS; info.bits[1] = 4'h8;
      end
      4'd5: begin
        info.count = 2'd2;
        info.sel[0] = SEL_ALPHA;  info.bits[0] = 4'hE;
        info.sel[1] = SEL_ALWAYS; info.bits[1] = 4'hA;
      end
      4'd6: begin
        info.count = 2'd3;
        info.sel[0] = SEL_GAMMA;  info.bits[0] = 4'h3;
        info.sel[1] = SEL_ALPHA;  info.bits[1] = 4'hD;
        info.sel[2] = SEL_ALWAYS; info.bits[2] = 4'h9;
      end
      4'd7, 4'd13: begin
        info.count = 2'd3;
        info.sel[0] = SEL_BETA;   info.bits[0] = 4'h8;
        info.sel[1] = SEL_ALPHA;  info.bits[1] = 4'hF;
        info.sel[2] = SEL_ALWAYS; info.bits[2] = 4'hB;
      end
      4'd8: begin
        info.count = 2'd2;
        info.sel[0] = SEL_ALPHA;  info.bits[0] = 4'hC;
        info.sel[1] = SEL_ALWAYS; info.bits[1] = 4'h4;
      end
      4'd9: begin
        info.count = 2'd3;
        info.sel[0] = SEL_ALPHA;  info.bits[0] = 4'hE;
        info.sel[1] = SEL_GAMMA;  info.bits[1] = 4'h3;
        info.sel[2] = SEL_ALWAYS; info.bits[2] = 4'h6;
      end
      4'd10: begin
        info.count = 2'd2;
        info.sel[0] = SEL_ALPHA;  info.bits[0] = 4'hD;
        info.sel[1] = SEL_ALWAYS; info.bits[1] = 4'h5;
      end
      4'd11: begin
        info.count = 2'd2;
        info.sel[0] = SEL_ALPHA; info.bits[0] = 4'hF;
        info.sel[1] = SEL_BETA;  info.bits[1] = 4'h4;
      end
      4'd14: begin
        info.count = 2'd2;
        info.sel[0] = SEL_GAMMA;  info.bits[0] = 4'hB;
        info.sel[1] = SEL_ALWAYS; info.bits[1] = 4'hD;
      end
      4'd15: begin
        info.count = 2'd1; info.sel[0] = SEL_BETA; info.bits[0] = 4'hC;
      end
      default: begin
        info = '0;
      end
    endcase
    return info;
  endfunction

endpackage

@@ sv/ppl_in_if.sv @@
// Input channel: valid/ready handshake carrying one load or update item.
interface ppl_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [ppl_pkg::SITE_W-1:0]       site;
  logic                             prey_value;
  logic                             predator_value;
  logic [ppl_pkg::DRAW_W-1:0]       choice_draw;
  logic [ppl_pkg::DRAW_W-1:0]       accept_draw;

  modport source (
    output valid, op, site, prey_value, predator_value, choice_draw, accept_draw,
    input  ready
  );
  modport sink (
    input  valid, op, site, prey_value, predator_value, choice_draw, accept_draw,
    output ready
  );
endinterface

@@ sv/ppl_out_if.sv @@
// Output channel: valid/ready handshake carrying one result item.
interface ppl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      prey_here;
  logic                      prey_next;
  logic                      predator_here;
  logic                      predator_next;
  logic [ppl_pkg::CNT_W-1:0] prey_total;
  logic [ppl_pkg::CNT_W-1:0] predator_total;

  modport source (
    output valid, prey_here, prey_next, predator_here, predator_next,
           prey_total, predator_total,
    input  ready
  );
  modport sink (
    input  valid, prey_here, prey_next, predator_here, predator_next,
           prey_total, predator_total,
    output ready
  );
endinterface

@@ sv/ppl_bank_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppl_bank_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ppl_rule.sv @@
// Pair rule: picks the option for a case code and decides whether it fires.
module ppl_rule (
  input  logic [3:0]                 code_i,
  input  logic [ppl_pkg::DRAW_W-1:0] choice_i,
  input  logic [ppl_pkg::DRAW_W-1:0] accept_i,
  input  ppl_pkg::thr_t              thr_i,
  output logic                       fire_o,
  output logic [3:0]                 bits_o
);

  ppl_pkg::case_t                  info;
  logic [ppl_pkg::DRAW_W+1:0]      triple;
  logic [1:0]                      opt;
  logic [1:0]                      sel;
  logic [ppl_pkg::THR_W-1:0]       thr_sel;

  always_comb begin
    info   = ppl_pkg::case_info(code_i);
    // choice * 3, top two bits give the third
    triple = {2'b00, choice_i} + {1'b0, choice_i, 1'b0};
    case (info.count)
      2'd2:    opt = {1'b0, choice_i[ppl_pkg::DRAW_W-1]};
      2'd3:    opt = triple[ppl_pkg::DRAW_W+1:ppl_pkg::DRAW_W];
      default: opt = 2'd0;
    endcase
    sel    = info.sel[opt];
    bits_o = info.bits[opt];
    case (sel)
      ppl_pkg::SEL_ALPHA: thr_sel = thr_i.alpha;
      ppl_pkg::SEL_BETA:  thr_sel = thr_i.beta;
      ppl_pkg::SEL_GAMMA: thr_sel = thr_i.gamma;
      default:            thr_sel = ppl_pkg::THR_ONE;
    endcase
    fire_o = (info.count != 2'd0) && ({1'b0, accept_i} < thr_sel);
  end

endmodule

@@ sv/predator_prey_lattice_pair_update.sv @@
// Top level of the predator-prey ring lattice pair update block.
//
// Usage:
//   in_i  carries load items (write one cell) and update items (apply the
//         pair rule to a site and its ring neighbour); out_o returns one
//         result item per input item, in order.
//   cfg_we_i/cfg_index_i/cfg_data_i write the alpha, beta and gamma
//   thresholds; write them only while no item is in flight.
// Path: each item goes through the compute stage and the result register.
// Throughput: one item per cycle unless out_o is held. The lattice sits in
//   two RAM banks split by site parity, so a pair touches one row in each
//   bank; each bank does one read and one write a cycle, and the last write
//   is forwarded to the item that read in the same cycle.
// Reset: thresholds and counts return to their defaults, then a clearing
//   pass zeroes all 512 rows of both banks with in_i.ready low.
// Stall: when out_o is held, the result register keeps its item, the item
//   behind it waits in the compute stage and in_i.ready drops.
module predator_prey_lattice_pair_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppl_in_if.sink                        in_i,
  ppl_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ppl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppl_pkg::THR_W-1:0]     cfg_data_i
);

  localparam int unsigned ROW_W = ppl_pkg::ROW_W;
  localparam int unsigned CNT_W = ppl_pkg::CNT_W;

  ppl_pkg::thr_t thr_q;

  // clearing pass
  logic             clr_active_q;
  logic [ROW_W-1:0] clr_row_q;

  // compute stage
  logic             s1_valid_q;
  logic             s1_op_q;
  logic             s1_par_q;
  logic             s1_in_range_q;
  logic [ROW_W-1:0] s1_ev_row_q;
  logic [ROW_W-1:0] s1_od_row_q;
  logic             s1_prey_q;
  logic             s1_pred_q;
  logic [ppl_pkg::DRAW_W-1:0] s1_choice_q;
  logic [ppl_pkg::DRAW_W-1:0] s1_accept_q;

  // forwarding of the last item write per bank
  logic             fwd_ev_v_q;
  logic [ROW_W-1:0] fwd_ev_row_q;
  ppl_pkg::cell_t   fwd_ev_data_q;
  logic             fwd_od_v_q;
  logic [ROW_W-1:0] fwd_od_row_q;
  ppl_pkg::cell_t   fwd_od_data_q;

  logic [CNT_W-1:0] prey_cnt_q;
  logic [CNT_W-1:0] pred_cnt_q;
  logic [CNT_W-1:0] prey_cnt_d;
  logic [CNT_W-1:0] pred_cnt_d;

  logic             out_valid_q;
  logic             out_ph_q;
  logic             out_pn_q;
  logic             out_dh_q;
  logic             out_dn_q;
  logic [CNT_W-1:0] out_prey_q;
  logic [CNT_W-1:0] out_pred_q;

  logic             adv;
  logic             in_accept;
  logic             s1_go;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] in_row_next;
  logic [ROW_W-1:0] rd_ev_row;
  logic             in_range;

  logic [1:0]       ev_rdata;
  logic [1:0]       od_rdata;
  ppl_pkg::cell_t   ev_cur;
  ppl_pkg::cell_t   od_cur;
  ppl_pkg::cell_t   cur_i;
  ppl_pkg::cell_t   cur_j;
  ppl_pkg::cell_t   new_i;
  ppl_pkg::cell_t   new_j;
  logic [3:0]       code;
  logic             fire;
  logic [3:0]       nb;
  logic             we_i_cell;
  logic             we_j_cell;
  logic             item_ev_we;
  logic             item_od_we;
  ppl_pkg::cell_t   item_ev_data;
  ppl_pkg::cell_t   item_od_data;

  logic             ev_we;
  logic             od_we;
  logic [ROW_W-1:0] ev_waddr;
  logic [ROW_W-1:0] od_waddr;
  logic [1:0]       ev_wdata;
  logic [1:0]       od_wdata;

  // handshake
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !clr_active_q && adv;
  assign in_accept  = in_i.valid && in_i.ready;
  assign s1_go      = s1_valid_q && adv;

  // read addresses: site i row and the neighbour row in the other bank
  assign in_row      = in_i.site[ROW_W:1];
  assign in_row_next = (in_row == ROW_W'(ppl_pkg::BANK_DEPTH - 1)) ? '0 : in_row + 1'b1;
  assign rd_ev_row   = in_i.site[0] ? in_row_next : in_row;
  assign in_range    = (32'(in_i.site) < ppl_pkg::SITES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.alpha <= ppl_pkg::ALPHA_RESET;
      thr_q.beta  <= ppl_pkg::BETA_RESET;
      thr_q.gamma <= ppl_pkg::GAMMA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ppl_pkg::REG_ALPHA: thr_q.alpha <= cfg_data_i;
        ppl_pkg::REG_BETA:  thr_q.beta  <= cfg_data_i;
        ppl_pkg::REG_GAMMA: thr_q.gamma <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_row_q    <= '0;
    end else if (clr_active_q) begin
      clr_row_q <= clr_row_q + 1'b1;
      if (clr_row_q == ROW_W'(ppl_pkg::BANK_DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= in_i.op;
      s1_par_q      <= in_i.site[0];
      s1_in_range_q <= in_range;
      s1_ev_row_q   <= rd_ev_row;
      s1_od_row_q   <= in_row;
      s1_prey_q     <= in_i.prey_value;
      s1_pred_q     <= in_i.predator_value;
      s1_choice_q   <= in_i.choice_draw;
      s1_accept_q   <= in_i.accept_draw;
    end
  end

  ppl_bank_ram #(
    .DEPTH (ppl_pkg::BANK_DEPTH),
    .WIDTH ($bits(ppl_pkg::cell_t))
  ) u_ev_bank (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .re_i    (in_accept),
    .raddr_i (rd_ev_row),
    .rdata_o (ev_rdata)
  );

  ppl_bank_ram #(
    .DEPTH (ppl_pkg::BANK_DEPTH),
    .WIDTH ($bits(ppl_pkg::cell_t))
  ) u_od_bank (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .re_i    (in_accept),
    .raddr_i (in_row),
    .rdata_o (od_rdata)
  );

  always_comb begin
    ev_cur = (fwd_ev_v_q && (fwd_ev_row_q == s1_ev_row_q)) ? fwd_ev_data_q
                                                           : ppl_pkg::cell_t'(ev_rdata);
    od_cur = (fwd_od_v_q && (fwd_od_row_q == s1_od_row_q)) ? fwd_od_data_q
                                                           : ppl_pkg::cell_t'(od_rdata);
    cur_i  = s1_par_q ? od_cur : ev_cur;
    cur_j  = s1_par_q ? ev_cur : od_cur;
    code   = {cur_i.prey, cur_j.prey, cur_i.pred, cur_j.pred};
  end

  ppl_rule u_rule (
    .code_i   (code),
    .choice_i (s1_choice_q),
    .accept_i (s1_accept_q),
    .thr_i    (thr_q),
    .fire_o   (fire),
    .bits_o   (nb)
  );

  always_comb begin
    if (s1_op_q == ppl_pkg::OP_LOAD) begin
      new_i     = '{prey: s1_prey_q, pred: s1_pred_q};
      new_j     = cur_j;
      we_i_cell = s1_in_range_q;
      we_j_cell = 1'b0;
    end else if (fire) begin
      new_i     = '{prey: nb[3], pred: nb[1]};
      new_j     = '{prey: nb[2], pred: nb[0]};
      we_i_cell = s1_in_range_q;
      we_j_cell = s1_in_range_q;
    end else begin
      new_i     = cur_i;
      new_j     = cur_j;
      we_i_cell = 1'b0;
      we_j_cell = 1'b0;
    end

    item_ev_we   = s1_go && (s1_par_q ? we_j_cell : we_i_cell);
    item_od_we   = s1_go && (s1_par_q ? we_i_cell : we_j_cell);
    item_ev_data = s1_par_q ? new_j : new_i;
    item_od_data = s1_par_q ? new_i : new_j;

    if (s1_in_range_q) begin
      prey_cnt_d = prey_cnt_q + CNT_W'(new_i.prey) + CNT_W'(new_j.prey)
                 - CNT_W'(cur_i.prey) - CNT_W'(cur_j.prey);
      pred_cnt_d = pred_cnt_q + CNT_W'(new_i.pred) + CNT_W'(new_j.pred)
                 - CNT_W'(cur_i.pred) - CNT_W'(cur_j.pred);
    end else begin
      prey_cnt_d = prey_cnt_q;
      pred_cnt_d = pred_cnt_q;
    end

    ev_we    = clr_active_q || item_ev_we;
    od_we    = clr_active_q || item_od_we;
    ev_waddr = clr_active_q ? clr_row_q : s1_ev_row_q;
    od_waddr = clr_active_q ? clr_row_q : s1_od_row_q;
    ev_wdata = clr_active_q ? '0 : item_ev_data;
    od_wdata = clr_active_q ? '0 : item_od_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_ev_v_q <= 1'b0;
      fwd_od_v_q <= 1'b0;
      prey_cnt_q <= '0;
      pred_cnt_q <= '0;
    end else begin
      if (item_ev_we) begin
        fwd_ev_v_q <= 1'b1;
      end
      if (item_od_we) begin
        fwd_od_v_q <= 1'b1;
      end
      if (s1_go) begin
        prey_cnt_q <= prey_cnt_d;
        pred_cnt_q <= pred_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ev_we) begin
      fwd_ev_row_q  <= s1_ev_row_q;
      fwd_ev_data_q <= item_ev_data;
    end
    if (item_od_we) begin
      fwd_od_row_q  <= s1_od_row_q;
      fwd_od_data_q <= item_od_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_ph_q   <= s1_in_range_q && new_i.prey;
      out_pn_q   <= s1_in_range_q && new_j.prey;
      out_dh_q   <= s1_in_range_q && new_i.pred;
      out_dn_q   <= s1_in_range_q && new_j.pred;
      out_prey_q <= prey_cnt_d;
      out_pred_q <= pred_cnt_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.prey_here      = out_ph_q;
  assign out_o.prey_next      = out_pn_q;
  assign out_o.predator_here  = out_dh_q;
  assign out_o.predator_next  = out_dn_q;
  assign out_o.prey_total     = out_prey_q;
  assign out_o.predator_total = out_pred_q;

  a_prey_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_prey_q) <= ppl_pkg::SITES))
    else $error("prey total above lattice size");

  a_pred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_pred_q) <= ppl_pkg::SITES))
    else $error("predator total above lattice size");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost before compute stage");

  a_clear_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_active_q) |-> (clr_row_q == '0) && !fwd_ev_v_q && !fwd_od_v_q)
    else $error("clearing pass ended early or with a pending forward");

endmodule

@@ verif/ppl_pair_checker.sv @@
// Checker for the predator-prey lattice block: watches both channels, predicts each result, compares.
module ppl_pair_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppl_in_if                             in_mon,
  ppl_out_if                            out_mon,
  input  logic                          cfg_we_i,
  input  logic [ppl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppl_pkg::THR_W-1:0]     cfg_data_i,
  output int unsigned                   owed_o,
  output int unsigned                   errors_o
);

  localparam int unsigned SITE_W = ppl_pkg::SITE_W;
  localparam int unsigned DRAW_W = ppl_pkg::DRAW_W;
  localparam int unsigned CNT_W  = ppl_pkg::CNT_W;

  typedef struct packed {
    logic             prey_here;
    logic             prey_next;
    logic             predator_here;
    logic             predator_next;
    logic [CNT_W-1:0] prey_total;
    logic [CNT_W-1:0] predator_total;
  } pair_view_t;

  // per case code: option count, threshold per option, new bits prey_i prey_j pred_i pred_j
  localparam int unsigned RULE_OPTIONS [16] = '{0, 1, 1, 1, 2, 2, 3, 3, 2, 3, 2, 2, 0, 3, 2, 1};
  localparam ppl_pkg::sel_e RULE_SEL [16][3] = '{
    '{ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_BETA,   ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_GAMMA,  ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_BETA,   ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_GAMMA,  ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_BETA,   ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_BETA,   ppl_pkg::SEL_ALPHA,  ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_GAMMA,  ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS},
    '{ppl_pkg::SEL_BETA,   ppl_pkg::SEL_ALWAYS, ppl_pkg::SEL_ALWAYS}
  };
  localparam logic [3:0] RULE_BITS [16][3] = '{
    '{4'h0, 4'h0, 4'h0}, '{4'h2, 4'h0, 4'h0}, '{4'h1, 4'h0, 4'h0}, '{4'h0, 4'h0, 4'h0},
    '{4'hC, 4'h8, 4'h0}, '{4'hE, 4'hA, 4'h0}, '{4'h3, 4'hD, 4'h9}, '{4'h8, 4'hF, 4'hB},
    '{4'hC, 4'h4, 4'h0}, '{4'hE, 4'h3, 4'h6}, '{4'hD, 4'h5, 4'h0}, '{4'hF, 4'h4, 4'h0},
    '{4'h0, 4'h0, 4'h0}, '{4'h8, 4'hF, 4'hB}, '{4'hB, 4'hD, 4'h0}, '{4'hC, 4'h0, 4'h0}
  };

  logic                      prey_map [ppl_pkg::SITES];
  logic                      pred_map [ppl_pkg::SITES];
  logic [CNT_W-1:0]          prey_sum;
  logic [CNT_W-1:0]          pred_sum;
  logic [ppl_pkg::THR_W-1:0] alpha_thr;
  logic [ppl_pkg::THR_W-1:0] beta_thr;
  logic [ppl_pkg::THR_W-1:0] gamma_thr;
  pair_view_t                owed_q [$];
  int unsigned               errors;
  int unsigned               results_seen;

  assign errors_o = errors;

  task automatic report_mismatch(input string msg);
    if (errors < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  function automatic void place_cell(input logic [SITE_W-1:0] idx, input logic prey,
                                     input logic pred);
    prey_sum      = prey_sum - CNT_W'(prey_map[idx]) + CNT_W'(prey);
    pred_sum      = pred_sum - CNT_W'(pred_map[idx]) + CNT_W'(pred);
    prey_map[idx] = prey;
    pred_map[idx] = pred;
  endfunction

  function automatic pair_view_t apply_item(input ppl_pkg::op_e op,
                                            input logic [SITE_W-1:0] site,
                                            input logic prey_v, input logic pred_v,
                                            input logic [DRAW_W-1:0] choice,
                                            input logic [DRAW_W-1:0] accept);
    logic [SITE_W-1:0]         nb;
    logic [3:0]                code;
    logic [DRAW_W+1:0]         scaled;
    logic [1:0]                opt;
    logic [ppl_pkg::THR_W-1:0] bar;
    logic [3:0]                fresh;
    pair_view_t                view;
    nb = (site == SITE_W'(ppl_pkg::SITES - 1)) ? '0 : site + 1'b1;
    if (op == ppl_pkg::OP_LOAD) begin
      place_cell(site, prey_v, pred_v);
    end else begin
      code = {prey_map[site], prey_map[nb], pred_map[site], pred_map[nb]};
      if (RULE_OPTIONS[code] != 0) begin
        scaled = {2'b00, choice} + {1'b0, choice, 1'b0};
        if (RULE_OPTIONS[code] == 2) begin
          opt = {1'b0, choice[DRAW_W-1]};
        end else if (RULE_OPTIONS[code] == 3) begin
          opt = scaled[DRAW_W+1:DRAW_W];
        end else begin
          opt = 2'd0;
        end
        case (RULE_SEL[code][opt])
          ppl_pkg::SEL_ALPHA: bar = alpha_thr;
          ppl_pkg::SEL_BETA:  bar = beta_thr;
          ppl_pkg::SEL_GAMMA: bar = gamma_thr;
          default:            bar = ppl_pkg::THR_ONE;
        endcase
        if ({1'b0, accept} < bar) begin
          fresh = RULE_BITS[code][opt];
          place_cell(site, fresh[3], fresh[1]);
          place_cell(nb, fresh[2], fresh[0]);
        end
      end
    end
    view.prey_here      = prey_map[site];
    view.prey_next      = prey_map[nb];
    view.predator_here  = pred_map[site];
    view.predator_next  = pred_map[nb];
    view.prey_total     = prey_sum;
    view.predator_total = pred_sum;
    return view;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pair_view_t want;
    if (!rst_ni) begin
      for (int n = 0; n < ppl_pkg::SITES; n++) begin
        prey_map[n] = 1'b0;
        pred_map[n] = 1'b0;
      end
      prey_sum     = '0;
      pred_sum     = '0;
      alpha_thr    = ppl_pkg::ALPHA_RESET;
      beta_thr     = ppl_pkg::BETA_RESET;
      gamma_thr    = ppl_pkg::GAMMA_RESET;
      owed_q.delete();
      results_seen = 0;
      owed_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ppl_pkg::REG_ALPHA: alpha_thr = cfg_data_i;
          ppl_pkg::REG_BETA:  beta_thr  = cfg_data_i;
          ppl_pkg::REG_GAMMA: gamma_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result item arrived with none owed");
        end else begin
          want = owed_q.pop_front();
          check_field("prey_here", 32'(out_mon.prey_here), 32'(want.prey_here));
          check_field("prey_next", 32'(out_mon.prey_next), 32'(want.prey_next));
          check_field("predator_here", 32'(out_mon.predator_here),
                      32'(want.predator_here));
          check_field("predator_next", 32'(out_mon.predator_next),
                      32'(want.predator_next));
          check_field("prey_total", 32'(out_mon.prey_total), 32'(want.prey_total));
          check_field("predator_total", 32'(out_mon.predator_total),
                      32'(want.predator_total));
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_q.push_back(apply_item(ppl_pkg::op_e'(in_mon.op), in_mon.site,
                                    in_mon.prey_value, in_mon.predator_value,
                                    in_mon.choice_draw, in_mon.accept_draw));
      end
      owed_o <= owed_q.size();
    end
  end

endmodule

@@ verif/tb_predator_prey_lattice_pair_update.sv @@
// Testbench top: clock, reset, stimulus, output back-pressure and verdict for the lattice block.
module tb_predator_prey_lattice_pair_update;

  localparam int unsigned SITE_W = ppl_pkg::SITE_W;
  localparam int unsigned DRAW_W = ppl_pkg::DRAW_W;
  localparam int unsigned THR_W  = ppl_pkg::THR_W;

  // index with no register behind it
  localparam logic [ppl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CHOICE_EDGES [8] = '{0, 21845, 21846, 32767, 32768, 43690, 43691,
                                               65535};

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [ppl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0]              cfg_data;
  int unsigned                   owed;
  int unsigned                   errors;
  int unsigned                   quiet = 0;
  int unsigned                   thr_now [3];
  int unsigned                   win_base;
  int unsigned                   win_len;
  int unsigned                   win_left;
  int                            send_run;
  int unsigned                   holds_asked = 0;
  int unsigned                   holds_done = 0;

  ppl_in_if  in_ch ();
  ppl_out_if out_ch ();

  predator_prey_lattice_pair_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ppl_pair_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .owed_o      (owed),
    .errors_o    (errors)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run > 0: items left with random gaps; run < 0: items left with none
  function automatic int unsigned next_gap(inout int run);
    if (run == 0) begin
      run = ($urandom_range(0, 2) == 0) ? -int'($urandom_range(8, 40))
                                        : int'($urandom_range(8, 40));
    end
    if (run < 0) begin
      run++;
      return 0;
    end
    run--;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [DRAW_W-1:0] pick_choice();
    if ($urandom_range(0, 3) == 0) begin
      return DRAW_W'(CHOICE_EDGES[$urandom_range(0, 7)]);
    end
    return DRAW_W'($urandom);
  endfunction

  function automatic logic [DRAW_W-1:0] pick_accept();
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 7);
    if (roll < 2) begin
      near = int'(thr_now[$urandom_range(0, 2)]) + int'($urandom_range(0, 2)) - 1;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return DRAW_W'(near);
    end
    if (roll == 2) return {DRAW_W{1'b1}};
    if (roll == 3) return '0;
    return DRAW_W'($urandom);
  endfunction

  task automatic send_item(input ppl_pkg::op_e op, input logic [SITE_W-1:0] site,
                           input logic prey_v, input logic pred_v,
                           input logic [DRAW_W-1:0] choice,
                           input logic [DRAW_W-1:0] accept);
    int unsigned gap;
    gap = next_gap(send_run);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.site           <= site;
    in_ch.prey_value     <= prey_v;
    in_ch.predator_value <= pred_v;
    in_ch.choice_draw    <= choice;
    in_ch.accept_draw    <= accept;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic load_cell(input logic [SITE_W-1:0] site, input logic prey_v,
                           input logic pred_v);
    send_item(ppl_pkg::OP_LOAD, site, prey_v, pred_v, DRAW_W'($urandom), DRAW_W'($urandom));
  endtask

  task automatic update_pair(input logic [SITE_W-1:0] site, input logic [DRAW_W-1:0] choice,
                             input logic [DRAW_W-1:0] accept);
    send_item(ppl_pkg::OP_UPDATE, site, 1'($urandom), 1'($urandom), choice, accept);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  task automatic write_reg(input logic [ppl_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= THR_W'(data);
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input int unsigned a, input int unsigned b,
                                input int unsigned g);
    drain();
    write_reg(ppl_pkg::REG_ALPHA, a);
    write_reg(ppl_pkg::REG_BETA, b);
    write_reg(REG_SPARE, $urandom_range(0, 131071));
    write_reg(ppl_pkg::REG_GAMMA, g);
    cfg_we <= 1'b0;
    thr_now[ppl_pkg::REG_ALPHA] = a;
    thr_now[ppl_pkg::REG_BETA]  = b;
    thr_now[ppl_pkg::REG_GAMMA] = g;
  endtask

  // mostly clustered in a small window of the ring so cells interact
  task automatic random_items(input int unsigned count);
    int unsigned       done;
    int unsigned       kind;
    logic [SITE_W-1:0] spot;
    done = 0;
    while (done < count) begin
      if (win_left == 0) begin
        win_base = $urandom_range(0, ppl_pkg::SITES - 1);
        win_len  = $urandom_range(2, 12);
        win_left = $urandom_range(20, 60);
      end
      win_left--;
      spot = SITE_W'(win_base + $urandom_range(0, win_len - 1));
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        load_cell(spot, 1'($urandom), 1'($urandom));
        load_cell(spot + 1'b1, 1'($urandom), 1'($urandom));
        update_pair(spot, pick_choice(), pick_accept());
        done += 3;
      end else if (kind < 35) begin
        load_cell(spot, 1'($urandom), 1'($urandom));
        done++;
      end else if (kind < 88) begin
        update_pair(spot, pick_choice(), pick_accept());
        done++;
      end else begin
        send_item(ppl_pkg::op_e'($urandom_range(0, 1)), SITE_W'($urandom), 1'($urandom),
                  1'($urandom), pick_choice(), pick_accept());
        done++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned gap;
    int          run;
    run           = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_done != holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done = holds_asked;
      end
      gap = next_gap(run);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    send_run                    = 0;
    win_left                    = 0;
    thr_now[ppl_pkg::REG_ALPHA] = 32'(ppl_pkg::ALPHA_RESET);
    thr_now[ppl_pkg::REG_BETA]  = 32'(ppl_pkg::BETA_RESET);
    thr_now[ppl_pkg::REG_GAMMA] = 32'(ppl_pkg::GAMMA_RESET);
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= ppl_pkg::REG_ALPHA;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= ppl_pkg::OP_UPDATE;
    in_ch.site           <= '0;
    in_ch.prey_value     <= 1'b0;
    in_ch.predator_value <= 1'b0;
    in_ch.choice_draw    <= '0;
    in_ch.accept_draw    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full pair across the wrap: beta clears predators, then nothing to do
    load_cell(SITE_W'(ppl_pkg::SITES - 1), 1'b1, 1'b1);
    load_cell(SITE_W'(0), 1'b1, 1'b1);
    update_pair(SITE_W'(ppl_pkg::SITES - 1), 16'hFFFF, 16'h0000);
    update_pair(SITE_W'(ppl_pkg::SITES - 1), 16'h0000, 16'h0000);
    load_cell(SITE_W'(0), 1'b0, 1'b0);
    load_cell(SITE_W'(1), 1'b0, 1'b0);
    update_pair(SITE_W'(0), 16'd32768, 16'h0000);
    // three-way cases at the thirds boundaries, then single-option cases
    load_cell(SITE_W'(5), 1'b1, 1'b0);
    load_cell(SITE_W'(6), 1'b0, 1'b1);
    update_pair(SITE_W'(5), 16'd43691, 16'hFFFF);
    update_pair(SITE_W'(5), 16'd0, 16'h0000);
    update_pair(SITE_W'(5), 16'd21845, 16'hFFFF);
    update_pair(SITE_W'(5), 16'd21846, 16'h0000);
    load_cell(SITE_W'(10), 1'b0, 1'b1);
    update_pair(SITE_W'(10), 16'd12345, 16'd40000);
    // two-way cases at the halves boundary
    load_cell(SITE_W'(20), 1'b1, 1'b0);
    load_cell(SITE_W'(21), 1'b0, 1'b0);
    update_pair(SITE_W'(20), 16'd32767, 16'h0000);
    load_cell(SITE_W'(21), 1'b0, 1'b0);
    update_pair(SITE_W'(20), 16'd32768, 16'hFFFF);
    load_cell(SITE_W'(100), 1'b1, 1'b1);
    load_cell(SITE_W'(101), 1'b1, 1'b0);
    update_pair(SITE_W'(100), 16'd21846, 16'hFFFF);
    update_pair(SITE_W'(100), 16'd43690, 16'hFFFF);

    random_items(200);
    set_thresholds(0, 0, 0);
    random_items(150);
    set_thresholds(65536, 65536, 65536);
    random_items(150);
    set_thresholds(131071, 65537, 98304);
    random_items(150);
    repeat (3) begin
      set_thresholds($urandom_range(0, 65536), $urandom_range(0, 65536),
                     $urandom_range(0, 65536));
      random_items(100);
      holds_asked++;
      random_items(100);
    end
    set_thresholds(32'(ppl_pkg::ALPHA_RESET), 32'(ppl_pkg::BETA_RESET),
                   32'(ppl_pkg::GAMMA_RESET));
    random_items(200);

    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ppl_pkg.sv
sv/ppl_in_if.sv
sv/ppl_out_if.sv
sv/ppl_bank_ram.sv
sv/ppl_rule.sv
sv/predator_prey_lattice_pair_update.sv
verif/ppl_pair_checker.sv
verif/tb_predator_prey_lattice_pair_update.sv
